### rtl/core/qpht_pkg.sv
// Shared types, constants and codes for the quadratic probe hash table.
package qpht_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int KEY_BITS    = 64;
  localparam int VALUE_BITS  = 64;
  localparam int IDX_BITS    = $clog2(TABLE_SLOTS);
  localparam int CNT_BITS    = 11;
  localparam int HASH_BITS   = 32;

  // Slot marks
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_FULL  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  // Operations
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_SCAN   = 2'd3;

  // Result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_SCAN_END  = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Register indexes
  localparam logic REG_SLOTS = 1'b0;
  localparam logic REG_MAX   = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture input transaction
    logic mod_start;  // start hash reduction
    logic mod_step;   // one restoring-division step
    logic rd_issue;   // issue a memory read at current index
    logic advance;    // move to next probe / scan slot
    logic clr_wr;     // clearing pass write
    logic clr_inc;
    logic commit;     // perform table write for the operation
    logic res_load;   // capture result into output register
    logic [1:0] res_status;
    logic res_hit;
  } qpht_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       mod_done;
    logic       mark_empty;
    logic       mark_full;
    logic       key_match;
    logic       probes_done;   // probe count reached size
    logic       scan_end;      // scan index at or past size
    logic       have_free;     // a free slot was seen on path
    logic       over_limit;    // live_count + 1 > max_entries
    logic       clr_done;
  } qpht_stat_t;

endpackage

### rtl/core/quadratic_probe_hash_table_unit.sv
// Top level of the quadratic probe hash table unit.
// Sequence: hash reduction, then a read, wait and evaluate per slot, one more read when
//   the probe count runs out; a new-key insert walks the path twice; scan skips it.
// Throughput: one transaction at a time; the probe loop over the single-read mark/key
//   memories sets the rate. Results are held in an output register until taken.
// Reset: synchronous; a clearing pass marks every slot empty, then idle.
module quadratic_probe_hash_table_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         op,
  input  logic [qpht_pkg::KEY_BITS-1:0]      key,
  input  logic [qpht_pkg::HASH_BITS-1:0]     key_hash,
  input  logic [qpht_pkg::VALUE_BITS-1:0]    new_value,
  input  logic [qpht_pkg::CNT_BITS-1:0]      start_slot,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic [63:0]                        found_value,
  output logic [63:0]                        found_key,
  output logic [qpht_pkg::CNT_BITS-1:0]      slot_index,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [qpht_pkg::CNT_BITS-1:0]      cfg_data
);

  qpht_pkg::qpht_cmd_t  cmd;
  qpht_pkg::qpht_stat_t stat;

  assign cfg_ready = 1'b1;

  qpht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat));

  qpht_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .op(op), .key(key), .key_hash(key_hash), .new_value(new_value),
    .start_slot(start_slot), .status(status), .found_value(found_value),
    .found_key(found_key), .slot_index(slot_index));

endmodule

### rtl/core/qpht_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module qpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/qpht_datapath.sv
// Datapath: hash reduction, probe index arithmetic, table memories, result register.
module qpht_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  qpht_pkg::qpht_cmd_t                cmd,
  output qpht_pkg::qpht_stat_t               stat,
  input  logic                               cfg_valid,
  input  logic                               cfg_index,
  input  logic [qpht_pkg::CNT_BITS-1:0]      cfg_data,
  input  logic [1:0]                         op,
  input  logic [qpht_pkg::KEY_BITS-1:0]      key,
  input  logic [qpht_pkg::HASH_BITS-1:0]     key_hash,
  input  logic [qpht_pkg::VALUE_BITS-1:0]    new_value,
  input  logic [qpht_pkg::CNT_BITS-1:0]      start_slot,
  output logic [1:0]                         status,
  output logic [63:0]                        found_value,
  output logic [63:0]                        found_key,
  output logic [qpht_pkg::CNT_BITS-1:0]      slot_index
);

  localparam int IW = qpht_pkg::IDX_BITS;
  localparam int CW = qpht_pkg::CNT_BITS;
  localparam int HW = qpht_pkg::HASH_BITS;
  localparam int HCW = $clog2(HW + 1);

  // configuration registers
  logic [CW-1:0] slots_in_use, max_entries, live_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= CW'(1023);
      max_entries  <= CW'(768);
    end else if (cfg_valid) begin
      if (cfg_index == qpht_pkg::REG_SLOTS) slots_in_use <= cfg_data;
      else                                  max_entries  <= cfg_data;
    end
  end

  // effective size, clamped to 1..TABLE_SLOTS
  logic [CW-1:0] size;
  always_comb begin
    if (slots_in_use == '0) size = CW'(1);
    else if (slots_in_use > CW'(qpht_pkg::TABLE_SLOTS)) size = CW'(qpht_pkg::TABLE_SLOTS);
    else size = slots_in_use;
  end

  // captured transaction
  logic [1:0]                      op_r;
  logic [qpht_pkg::KEY_BITS-1:0]   key_r;
  logic [HW-1:0]                   hash_r;
  logic [qpht_pkg::VALUE_BITS-1:0] val_r;

  // restoring division for hash mod size, one quotient bit per cycle
  logic [CW:0]    rem;
  logic [HCW-1:0] mod_cnt;
  logic [CW:0]    rem_shift;
  assign rem_shift = {rem[CW-1:0], hash_r[HW-1]};

  // probe state
  logic [CW-1:0] idx, step, nprobe;
  logic [CW-1:0] free_idx;
  logic          have_free;
  logic [CW:0]   idx_sum;
  logic [CW:0]   idx_wrap;
  assign idx_sum  = {1'b0, idx} + {1'b0, step};
  assign idx_wrap = idx_sum - {1'b0, size};

  // clearing pass counter
  logic [IW:0] clr_cnt;

  // memories
  logic [1:0]                      mark_rd;
  logic [qpht_pkg::KEY_BITS-1:0]   key_rd;
  logic [qpht_pkg::VALUE_BITS-1:0] val_rd;
  logic         mark_we, kv_we, val_we;
  logic [IW-1:0] waddr;
  logic [1:0]    mark_wd;

  always_comb begin
    mark_we = 1'b0;
    kv_we   = 1'b0;
    val_we  = 1'b0;
    waddr   = idx[IW-1:0];
    mark_wd = qpht_pkg::MARK_FULL;
    if (cmd.clr_wr) begin
      mark_we = 1'b1;
      waddr   = clr_cnt[IW-1:0];
      mark_wd = qpht_pkg::MARK_EMPTY;
    end else if (cmd.commit) begin
      unique case (op_r)
        qpht_pkg::OP_INSERT: begin
          val_we = 1'b1;
          if (!cmd.res_hit) begin
            waddr   = free_idx[IW-1:0];
            mark_we = 1'b1;
            kv_we   = 1'b1;
          end
        end
        qpht_pkg::OP_REMOVE: begin
          mark_we = 1'b1;
          mark_wd = qpht_pkg::MARK_TOMB;
        end
        default: ;
      endcase
    end
  end

  qpht_ram #(.WIDTH(2), .DEPTH(qpht_pkg::TABLE_SLOTS)) u_marks (
    .clk(clk), .we(mark_we), .waddr(waddr), .wdata(mark_wd),
    .raddr(idx[IW-1:0]), .rdata(mark_rd));
  qpht_ram #(.WIDTH(qpht_pkg::KEY_BITS), .DEPTH(qpht_pkg::TABLE_SLOTS)) u_keys (
    .clk(clk), .we(kv_we), .waddr(waddr), .wdata(key_r),
    .raddr(idx[IW-1:0]), .rdata(key_rd));
  qpht_ram #(.WIDTH(qpht_pkg::VALUE_BITS), .DEPTH(qpht_pkg::TABLE_SLOTS)) u_vals (
    .clk(clk), .we(val_we), .waddr(waddr), .wdata(val_r),
    .raddr(idx[IW-1:0]), .rdata(val_rd));

  // sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      live_count <= '0;
    end else begin
      if (cmd.clr_inc) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.commit && !cmd.res_hit && op_r == qpht_pkg::OP_INSERT)
        live_count <= live_count + 1'b1;
      if (cmd.commit && op_r == qpht_pkg::OP_REMOVE && live_count != '0)
        live_count <= live_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op;
      key_r  <= key;
      hash_r <= key_hash;
      val_r  <= new_value;
      idx    <= start_slot;
    end
    if (cmd.mod_start) begin
      rem     <= '0;
      mod_cnt <= '0;
    end else if (cmd.mod_step) begin
      // rotate, so the hash is whole again for a second pass
      hash_r  <= {hash_r[HW-2:0], hash_r[HW-1]};
      mod_cnt <= mod_cnt + 1'b1;
      if (rem_shift >= {1'b0, size}) rem <= rem_shift - {1'b0, size};
      else                           rem <= rem_shift;
      if (mod_cnt == HCW'(HW - 1)) begin
        idx <= (rem_shift >= {1'b0, size}) ? CW'(rem_shift - {1'b0, size})
                                           : CW'(rem_shift);
        step      <= CW'(1);
        nprobe    <= '0;
        have_free <= 1'b0;
      end
    end
    if (cmd.advance) begin
      if (op_r == qpht_pkg::OP_SCAN) begin
        idx <= idx + 1'b1;
      end else begin
        if (!have_free && mark_rd != qpht_pkg::MARK_FULL) begin
          have_free <= 1'b1;
          free_idx  <= idx;
        end
        idx    <= (idx_sum >= {1'b0, size}) ? CW'(idx_wrap) : CW'(idx_sum);
        // step stays below size when size is at least 2: it is reduced the same way
        step   <= (step + CW'(2) >= size) ? CW'(step + CW'(2) - size) : CW'(step + CW'(2));
        nprobe <= nprobe + 1'b1;
      end
    end
    if (cmd.rd_issue && 1'b0) free_idx <= idx;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status      <= cmd.res_status;
      found_value <= '0;
      found_key   <= '0;
      slot_index  <= '0;
      if (cmd.res_status == qpht_pkg::ST_SCAN_END) slot_index <= size;
      if (cmd.res_status == qpht_pkg::ST_OK) begin
        unique case (op_r)
          qpht_pkg::OP_INSERT: slot_index <= cmd.res_hit ? idx : free_idx;
          qpht_pkg::OP_GET: begin
            slot_index  <= idx;
            found_value <= 64'(val_rd);
          end
          qpht_pkg::OP_REMOVE: slot_index <= idx;
          qpht_pkg::OP_SCAN: begin
            slot_index <= idx;
            found_key  <= 64'(key_rd);
          end
          default: ;
        endcase
      end
    end
  end

  // status to controller
  assign stat.op          = op_r;
  assign stat.mod_done    = (mod_cnt == HCW'(HW));
  assign stat.mark_empty  = (mark_rd == qpht_pkg::MARK_EMPTY);
  assign stat.mark_full   = (mark_rd == qpht_pkg::MARK_FULL);
  assign stat.key_match   = (key_rd == key_r);
  assign stat.probes_done = (nprobe >= size);
  assign stat.scan_end    = (idx >= size);
  assign stat.have_free   = have_free;
  assign stat.over_limit  = ({1'b0, live_count} + 1'b1) > {1'b0, max_entries};
  assign stat.clr_done    = clr_cnt[IW];

endmodule

### rtl/core/qpht_ctrl.sv
// Controller state machine: clearing pass, hash reduction, probe and scan loops, output handshake.
module qpht_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output qpht_pkg::qpht_cmd_t   cmd,
  input  qpht_pkg::qpht_stat_t  stat
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MOD   = 8'b0000_0100,
    S_READ  = 8'b0000_1000,
    S_WAIT  = 8'b0001_0000,
    S_EVAL  = 8'b0010_0000,
    S_FREE  = 8'b0100_0000,
    S_HOLD  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  // S_FREE revisits the probe path for insert after a miss
  logic second_pass, second_pass_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    out_valid_next = out_valid && out_stall;
    second_pass_next = second_pass;
    in_stall = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.clr_inc = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = out_valid && out_stall;
        if (in_valid && !in_stall) begin
          cmd.load   = 1'b1;
          cmd.mod_start = 1'b1;
          second_pass_next = 1'b0;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (stat.op == qpht_pkg::OP_SCAN) begin
          state_next = S_READ;
        end else if (stat.mod_done) begin
          state_next = S_READ;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_READ: begin
        // read address is current index, data valid next cycle
        cmd.rd_issue = 1'b1;
        if (stat.op == qpht_pkg::OP_SCAN ? stat.scan_end : stat.probes_done) begin
          state_next = S_HOLD;
          if (stat.op == qpht_pkg::OP_SCAN) begin
            cmd.res_load = 1'b1;
            cmd.res_status = qpht_pkg::ST_SCAN_END;
          end else if (stat.op == qpht_pkg::OP_INSERT && !second_pass) begin
            state_next = S_FREE;
          end else if (stat.op == qpht_pkg::OP_INSERT) begin
            cmd.res_load = 1'b1;
            cmd.res_status = qpht_pkg::ST_FULL;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_status = qpht_pkg::ST_NOT_FOUND;
          end
        end else begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: state_next = S_EVAL;
      S_EVAL: begin
        state_next = S_READ;
        if (stat.op == qpht_pkg::OP_SCAN) begin
          if (stat.mark_full) begin
            cmd.res_load = 1'b1;
            cmd.res_status = qpht_pkg::ST_OK;
            state_next = S_HOLD;
          end else begin
            cmd.advance = 1'b1;
          end
        end else if (second_pass) begin
          // looking for first non-full slot
          if (!stat.mark_full) begin
            cmd.advance = 1'b1;   // latches free index
            state_next = S_FREE;
          end else begin
            cmd.advance = 1'b1;
          end
        end else if (stat.mark_empty) begin
          if (stat.op == qpht_pkg::OP_INSERT) begin
            state_next = S_FREE;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_status = qpht_pkg::ST_NOT_FOUND;
            state_next = S_HOLD;
          end
        end else if (stat.mark_full && stat.key_match) begin
          cmd.res_load = 1'b1;
          cmd.res_status = qpht_pkg::ST_OK;
          cmd.res_hit = 1'b1;
          if (stat.op != qpht_pkg::OP_GET) cmd.commit = 1'b1;
          state_next = S_HOLD;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_FREE: begin
        // insert miss: full past max_entries, else re-probe to the first free slot and commit there
        if (!second_pass) begin
          if (stat.over_limit) begin
            cmd.res_load = 1'b1;
            cmd.res_status = qpht_pkg::ST_FULL;
            state_next = S_HOLD;
          end else begin
            second_pass_next = 1'b1;
            cmd.mod_start = 1'b1;
            state_next = S_MOD;
          end
        end else begin
          cmd.commit = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_status = qpht_pkg::ST_OK;
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      out_valid   <= 1'b0;
      second_pass <= 1'b0;
    end else begin
      state       <= state_next;
      out_valid   <= out_valid_next;
      second_pass <= second_pass_next;
    end
  end

  // no transaction accepted during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> in_stall) else $error("accept during clear");
  // a result is raised only out of the hold state
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_HOLD) else $error("stray result");
  // commit only alongside a result capture
  a_commit_res: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> cmd.res_load) else $error("commit without result");

endmodule
